// ===== rtl/gmrc_pkg.sv =====
// shared types, codes and constants of the guarded monotonic and realtime clock
`timescale 1ns / 1ps

package gmrc_pkg;

    localparam int NOW_W    = 63;
    localparam int SEC_W    = 34;
    localparam int NSEC_W   = 30;
    localparam int ID_W     = 4;
    localparam int WANT_W   = 64;
    localparam int CALC_W   = 66;
    localparam int QUOT_W   = 34;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [NOW_W-1:0]  VALUE_MAX  = {NOW_W{1'b1}};
    localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1_000_000_000;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic [ID_W-1:0] CLK_REALTIME         = 4'd0;
    localparam logic [ID_W-1:0] CLK_MONOTONIC        = 4'd1;
    localparam logic [ID_W-1:0] CLK_REALTIME_COARSE  = 4'd5;
    localparam logic [ID_W-1:0] CLK_MONOTONIC_COARSE = 4'd6;
    localparam logic [ID_W-1:0] CLK_BOOTTIME         = 4'd7;

    localparam logic CFG_REALTIME_START = 1'b0;
    localparam logic CFG_MONOTIME_START = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_GET_MONO,
        KIND_GET_REAL,
        KIND_SET,
        KIND_BAD
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [NOW_W-1:0]   host_now;
        logic [WANT_W-1:0]  want;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [NOW_W-1:0]   value;
    } result_t;

endpackage

// ===== rtl/gmrc_front.sv =====
// request front end: accepts beats, classifies them and forms the requested set time
`timescale 1ns / 1ps

module gmrc_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [gmrc_pkg::ID_W-1:0]      s_clock_id,
    input  logic [gmrc_pkg::NOW_W-1:0]     s_host_now,
    input  logic [gmrc_pkg::SEC_W-1:0]     s_set_seconds,
    input  logic [gmrc_pkg::NSEC_W-1:0]    s_set_nanoseconds,
    output logic                           push_valid,
    input  logic                           push_ready,
    output gmrc_pkg::item_t                push_item
);

    logic                           front_valid_reg;
    gmrc_pkg::item_t                item_reg;
    gmrc_pkg::item_t                item_next;
    logic [gmrc_pkg::WANT_W-1:0]    product;

    always_comb begin
        product = gmrc_pkg::WANT_W'(s_set_seconds) * gmrc_pkg::WANT_W'(gmrc_pkg::NS_PER_SEC);
        item_next.host_now = s_host_now;
        item_next.want     = product + gmrc_pkg::WANT_W'(s_set_nanoseconds);
        if (s_operation == gmrc_pkg::OP_SET) begin
            item_next.kind = (s_clock_id == gmrc_pkg::CLK_REALTIME) ?
                             gmrc_pkg::KIND_SET : gmrc_pkg::KIND_BAD;
        end else if (s_clock_id == gmrc_pkg::CLK_MONOTONIC ||
                     s_clock_id == gmrc_pkg::CLK_MONOTONIC_COARSE ||
                     s_clock_id == gmrc_pkg::CLK_BOOTTIME) begin
            item_next.kind = gmrc_pkg::KIND_GET_MONO;
        end else if (s_clock_id == gmrc_pkg::CLK_REALTIME ||
                     s_clock_id == gmrc_pkg::CLK_REALTIME_COARSE) begin
            item_next.kind = gmrc_pkg::KIND_GET_REAL;
        end else begin
            item_next.kind = gmrc_pkg::KIND_BAD;
        end
    end

    assign s_ready    = !front_valid_reg || push_ready;
    assign push_valid = front_valid_reg;
    assign push_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_ready) begin
            front_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/gmrc_queue.sv =====
// short request queue between the front end and the clock state pipeline
`timescale 1ns / 1ps

module gmrc_queue #(
    parameter int DEPTH = gmrc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  gmrc_pkg::item_t    push_item,
    input  logic               pop,
    output logic               pop_valid,
    output gmrc_pkg::item_t    pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gmrc_pkg::item_t    mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/gmrc_back.sv =====
// clock state pipeline: monotonic guard, realtime sum and forward-only offset
`timescale 1ns / 1ps

module gmrc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [gmrc_pkg::NOW_W-1:0]  cfg_data,
    input  logic                        en,
    input  logic                        in_valid,
    input  gmrc_pkg::item_t             in_item,
    output logic                        out_valid,
    output gmrc_pkg::result_t           out_result
);

    localparam int NW = gmrc_pkg::NOW_W;
    localparam int CW = gmrc_pkg::CALC_W;
    localparam logic signed [CW-1:0] MAX_EXT = {{(CW - NW){1'b0}}, gmrc_pkg::VALUE_MAX};

    logic [NW-1:0]  realtime_start_reg;
    logic [NW-1:0]  monotime_start_reg;
    logic [NW-1:0]  last_monotonic_reg;
    logic [NW-1:0]  last_monotonic_next;
    logic [NW-1:0]  realtime_offset_reg;

    // monotonic guard
    logic [NW-1:0]  prev;
    logic [NW-1:0]  prev_inc;
    logic           now_ahead;
    logic           prev_at_max;
    logic           mono_update;

    logic                       b1_valid_reg;
    gmrc_pkg::kind_t            b1_kind_reg;
    logic [NW-1:0]              b1_mono_reg;
    logic                       b1_fail_reg;
    logic [gmrc_pkg::WANT_W-1:0] b1_want_reg;

    logic                       b2_valid_reg;
    gmrc_pkg::kind_t            b2_kind_reg;
    logic [NW-1:0]              b2_mono_reg;
    logic                       b2_fail_reg;
    logic [gmrc_pkg::WANT_W-1:0] b2_want_reg;
    logic signed [CW-1:0]       b2_base_reg;
    logic signed [CW-1:0]       b2_base_next;

    logic                       b3_valid_reg;
    gmrc_pkg::kind_t            b3_kind_reg;
    logic [NW-1:0]              b3_mono_reg;
    logic                       b3_fail_reg;
    logic signed [CW-1:0]       b3_base_reg;
    logic signed [CW-1:0]       b3_lo_reg;
    logic signed [CW-1:0]       b3_hi_reg;
    logic signed [CW-1:0]       b3_cand_reg;

    logic                       out_valid_reg;
    gmrc_pkg::result_t          out_result_reg;
    gmrc_pkg::result_t          out_result_next;

    // offset stage
    logic signed [CW-1:0]       offset_ext;
    logic signed [CW-1:0]       realtime_sum;
    logic                       real_ok;
    logic                       advance;
    logic                       fits;
    logic                       offset_write;

    always_comb begin
        prev        = (last_monotonic_reg == '0) ? monotime_start_reg : last_monotonic_reg;
        prev_inc    = prev + 1'b1;
        now_ahead   = in_item.host_now > prev;
        prev_at_max = (prev == gmrc_pkg::VALUE_MAX);
        if (now_ahead) begin
            last_monotonic_next = in_item.host_now;
        end else if (prev_at_max) begin
            last_monotonic_next = prev;
        end else begin
            last_monotonic_next = prev_inc;
        end
        mono_update = en && in_valid && (in_item.kind != gmrc_pkg::KIND_BAD);
    end

    assign b2_base_next = CW'(b1_mono_reg) - CW'(monotime_start_reg) + CW'(realtime_start_reg);

    always_comb begin
        offset_ext   = CW'(realtime_offset_reg);
        realtime_sum = b3_base_reg + offset_ext;
        real_ok      = !b3_fail_reg && (offset_ext >= b3_lo_reg) && (offset_ext <= b3_hi_reg);
        advance      = b3_cand_reg > offset_ext;
        fits         = b3_cand_reg <= MAX_EXT;
        offset_write = 1'b0;
        out_result_next.value = '0;
        unique case (b3_kind_reg)
            gmrc_pkg::KIND_GET_MONO: begin
                out_result_next.status = b3_fail_reg ? gmrc_pkg::STATUS_OVERFLOW :
                                                       gmrc_pkg::STATUS_OK;
                out_result_next.value  = b3_fail_reg ? '0 : b3_mono_reg;
            end
            gmrc_pkg::KIND_GET_REAL: begin
                out_result_next.status = real_ok ? gmrc_pkg::STATUS_OK :
                                                   gmrc_pkg::STATUS_OVERFLOW;
                out_result_next.value  = real_ok ? realtime_sum[NW-1:0] : '0;
            end
            gmrc_pkg::KIND_SET: begin
                if (!real_ok) begin
                    out_result_next.status = gmrc_pkg::STATUS_OVERFLOW;
                end else if (advance && !fits) begin
                    out_result_next.status = gmrc_pkg::STATUS_INVALID;
                end else begin
                    out_result_next.status = gmrc_pkg::STATUS_OK;
                    offset_write           = advance;
                end
            end
            gmrc_pkg::KIND_BAD: begin
                out_result_next.status = gmrc_pkg::STATUS_INVALID;
            end
            default: begin
                out_result_next.status = gmrc_pkg::STATUS_INVALID;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            realtime_start_reg  <= NW'(1);
            monotime_start_reg  <= NW'(1);
            last_monotonic_reg  <= '0;
            realtime_offset_reg <= '0;
            b1_valid_reg        <= 1'b0;
            b2_valid_reg        <= 1'b0;
            b3_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end else begin
            if (cfg_write) begin
                if (cfg_index == gmrc_pkg::CFG_REALTIME_START) begin
                    realtime_start_reg <= cfg_data;
                end else begin
                    monotime_start_reg <= cfg_data;
                end
            end
            if (mono_update) begin
                last_monotonic_reg <= last_monotonic_next;
            end
            if (en && b3_valid_reg && offset_write) begin
                realtime_offset_reg <= b3_cand_reg[NW-1:0];
            end
            if (en) begin
                b1_valid_reg  <= in_valid;
                b2_valid_reg  <= b1_valid_reg;
                b3_valid_reg  <= b2_valid_reg;
                out_valid_reg <= b3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_kind_reg    <= in_item.kind;
            b1_mono_reg    <= now_ahead ? in_item.host_now : prev_inc;
            b1_fail_reg    <= !now_ahead && prev_at_max;
            b1_want_reg    <= in_item.want;

            b2_kind_reg    <= b1_kind_reg;
            b2_mono_reg    <= b1_mono_reg;
            b2_fail_reg    <= b1_fail_reg;
            b2_want_reg    <= b1_want_reg;
            b2_base_reg    <= b2_base_next;

            b3_kind_reg    <= b2_kind_reg;
            b3_mono_reg    <= b2_mono_reg;
            b3_fail_reg    <= b2_fail_reg;
            b3_base_reg    <= b2_base_reg;
            b3_lo_reg      <= -b2_base_reg;
            b3_hi_reg      <= MAX_EXT - b2_base_reg;
            b3_cand_reg    <= CW'(b2_want_reg) - b2_base_reg;

            out_result_reg <= out_result_next;
        end
    end

endmodule

// ===== rtl/gmrc_div.sv =====
// result stage: splits the clock value into seconds and nanoseconds by reciprocal multiplication
`timescale 1ns / 1ps

module gmrc_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  gmrc_pkg::result_t               in_result,
    output logic                            m_valid,
    output logic [1:0]                      m_status,
    output logic [gmrc_pkg::SEC_W-1:0]      m_seconds,
    output logic [gmrc_pkg::NSEC_W-1:0]     m_nanoseconds
);

    // one second is 2^9 times 5^9: the low 9 bits pass through, the rest is divided by 5^9
    localparam int NW  = gmrc_pkg::NOW_W;
    localparam int QW  = gmrc_pkg::QUOT_W;
    localparam int SW  = 9;
    localparam int VW  = NW - SW;
    localparam int HW  = VW / 2;
    localparam int OW  = gmrc_pkg::NSEC_W - SW;
    localparam int RW  = 55;
    localparam int RLW = 28;
    localparam int LLW = HW + RLW;
    localparam int LHW = HW + RW - RLW;
    localparam int HLW = VW - HW + RLW;
    localparam int HHW = VW - HW + RW - RLW;
    localparam int XW  = LLW + 1;
    localparam int PW  = VW + RW;
    localparam int PSH = VW + OW;

    // ceil(2^75 / 5^9), exact for every 54-bit dividend
    localparam logic [OW-1:0] ODD   = 21'd1_953_125;
    localparam logic [RW-1:0] RECIP = 55'd19_342_813_113_834_067;

    logic [VW-1:0]          scaled;
    logic [HW-1:0]          scaled_lo;
    logic [VW-HW-1:0]       scaled_hi;
    logic [PW-1:0]          product;
    logic [QW-1:0]          quot;
    logic [OW-1:0]          quot_times_odd;
    logic [OW-1:0]          rem_odd;

    logic                   d1_valid_reg;
    gmrc_pkg::status_t      d1_status_reg;
    logic [SW-1:0]          d1_low_reg;
    logic [OW-1:0]          d1_tail_reg;
    logic [LLW-1:0]         d1_ll_reg;
    logic [LHW-1:0]         d1_lh_reg;
    logic [HLW-1:0]         d1_hl_reg;
    logic [HHW-1:0]         d1_hh_reg;

    logic                   d2_valid_reg;
    gmrc_pkg::status_t      d2_status_reg;
    logic [SW-1:0]          d2_low_reg;
    logic [OW-1:0]          d2_tail_reg;
    logic [LLW-1:0]         d2_ll_reg;
    logic [XW-1:0]          d2_cross_reg;
    logic [HHW-1:0]         d2_hh_reg;

    logic                   d3_valid_reg;
    gmrc_pkg::status_t      d3_status_reg;
    logic [SW-1:0]          d3_low_reg;
    logic [OW-1:0]          d3_tail_reg;
    logic [QW-1:0]          d3_quot_reg;

    logic                   d4_valid_reg;
    gmrc_pkg::status_t      d4_status_reg;
    logic [QW-1:0]          d4_sec_reg;
    logic [gmrc_pkg::NSEC_W-1:0] d4_nsec_reg;

    always_comb begin
        scaled         = in_result.value[NW-1:SW];
        scaled_lo      = scaled[HW-1:0];
        scaled_hi      = scaled[VW-1:HW];
        product        = PW'(d2_ll_reg) + (PW'(d2_cross_reg) << HW) +
                         (PW'(d2_hh_reg) << (HW + RLW));
        quot           = product[PW-1:PSH];
        quot_times_odd = d3_quot_reg[OW-1:0] * ODD;
        rem_odd        = d3_tail_reg - quot_times_odd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            d4_valid_reg <= 1'b0;
        end else if (en) begin
            d1_valid_reg <= in_valid;
            d2_valid_reg <= d1_valid_reg;
            d3_valid_reg <= d2_valid_reg;
            d4_valid_reg <= d3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_status_reg <= in_result.status;
            d1_low_reg    <= in_result.value[SW-1:0];
            d1_tail_reg   <= scaled[OW-1:0];
            d1_ll_reg     <= LLW'(scaled_lo) * LLW'(RECIP[RLW-1:0]);
            d1_lh_reg     <= LHW'(scaled_lo) * LHW'(RECIP[RW-1:RLW]);
            d1_hl_reg     <= HLW'(scaled_hi) * HLW'(RECIP[RLW-1:0]);
            d1_hh_reg     <= HHW'(scaled_hi) * HHW'(RECIP[RW-1:RLW]);

            d2_status_reg <= d1_status_reg;
            d2_low_reg    <= d1_low_reg;
            d2_tail_reg   <= d1_tail_reg;
            d2_ll_reg     <= d1_ll_reg;
            d2_cross_reg  <= XW'({d1_lh_reg, 1'b0}) + XW'(d1_hl_reg);
            d2_hh_reg     <= d1_hh_reg;

            d3_status_reg <= d2_status_reg;
            d3_low_reg    <= d2_low_reg;
            d3_tail_reg   <= d2_tail_reg;
            d3_quot_reg   <= quot;

            d4_status_reg <= d3_status_reg;
            d4_sec_reg    <= d3_quot_reg;
            d4_nsec_reg   <= {rem_odd, d3_low_reg};
        end
    end

    assign m_valid       = d4_valid_reg;
    assign m_status      = d4_status_reg;
    assign m_seconds     = d4_sec_reg;
    assign m_nanoseconds = d4_nsec_reg;

endmodule

// ===== rtl/guarded_monotonic_realtime_clock.sv =====
// top level of the guarded monotonic and realtime clock
//
//   channel   direction  handshake         payload
//   s_        in         s_valid/s_ready   operation, clock_id, host_now, set_seconds,
//                                          set_nanoseconds
//   m_        out        m_valid/m_ready   status, seconds, nanoseconds
//   cfg_      in         cfg_write         cfg_index, cfg_data (no read-back)
//
// one beat per cycle sustained while m_ready does not stall the output; a result passes
// the front register, the queue, the clock state stages and the seconds split stages.
// the monotonic guard and the offset update each take effect before the next beat reaches
// them, so beats follow each other without gaps.
// reset clears the kept monotonic value and the offset and sets both start registers to 1.
// a stall on m_ready holds the back pipeline; the front keeps taking beats until the
// queue fills.
`timescale 1ns / 1ps

module guarded_monotonic_realtime_clock #(
    parameter int QUEUE_DEPTH = gmrc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [gmrc_pkg::ID_W-1:0]       s_clock_id,
    input  logic [gmrc_pkg::NOW_W-1:0]      s_host_now,
    input  logic [gmrc_pkg::SEC_W-1:0]      s_set_seconds,
    input  logic [gmrc_pkg::NSEC_W-1:0]     s_set_nanoseconds,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [gmrc_pkg::SEC_W-1:0]      m_seconds,
    output logic [gmrc_pkg::NSEC_W-1:0]     m_nanoseconds,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [gmrc_pkg::NOW_W-1:0]      cfg_data
);

    logic               push_valid;
    logic               push_ready;
    gmrc_pkg::item_t    push_item;
    logic               pop_valid;
    gmrc_pkg::item_t    pop_item;
    logic               pipe_en;
    logic               back_valid;
    gmrc_pkg::result_t  back_result;

    assign pipe_en = !m_valid || m_ready;

    gmrc_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_clock_id        (s_clock_id),
        .s_host_now        (s_host_now),
        .s_set_seconds     (s_set_seconds),
        .s_set_nanoseconds (s_set_nanoseconds),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_item         (push_item)
    );

    gmrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop        (pipe_en),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    gmrc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .en         (pipe_en),
        .in_valid   (pop_valid),
        .in_item    (pop_item),
        .out_valid  (back_valid),
        .out_result (back_result)
    );

    gmrc_div u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (pipe_en),
        .in_valid      (back_valid),
        .in_result     (back_result),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_seconds     (m_seconds),
        .m_nanoseconds (m_nanoseconds)
    );

endmodule

// ===== bench/clock_check_pkg.sv =====
// request predictor and reading checks for the guarded clock bench
`timescale 1ns / 1ps

package clock_check_pkg;

    import gmrc_pkg::*;

    typedef struct {
        status_t           status;
        logic [SEC_W-1:0]  seconds;
        logic [NSEC_W-1:0] nanoseconds;
    } reading_t;

    class clock_checker;
        logic [NOW_W-1:0] realtime_start;
        logic [NOW_W-1:0] monotime_start;
        logic [NOW_W-1:0] kept_mono;
        logic [NOW_W-1:0] rt_offset;
        reading_t         expected_readings[$];
        int               requests;
        int               readings;
        int               errors;
        int               by_status[3];

        function new();
            realtime_start = 1;
            monotime_start = 1;
            kept_mono = '0;
            rt_offset = '0;
            requests = 0;
            readings = 0;
            errors = 0;
            foreach (by_status[i]) by_status[i] = 0;
        endfunction

        function void write_register(logic idx, logic [NOW_W-1:0] data);
            if (idx == CFG_REALTIME_START) begin
                realtime_start = data;
            end else begin
                monotime_start = data;
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // rough current realtime, used only to aim set requests
        function logic [63:0] realtime_guess(logic [NOW_W-1:0] host);
            return {1'b0, host} - {1'b0, monotime_start} + {1'b0, realtime_start}
                + {1'b0, rt_offset};
        endfunction

        function bit mono_read(input logic [NOW_W-1:0] host, output logic [NOW_W-1:0] val);
            logic [NOW_W-1:0] p;
            p = (kept_mono == '0) ? monotime_start : kept_mono;
            val = '0;
            if (host > p) begin
                kept_mono = host;
                val = host;
                return 1'b1;
            end
            if (p == VALUE_MAX) begin
                kept_mono = VALUE_MAX;
                return 1'b0;
            end
            kept_mono = p + 1'b1;
            val = kept_mono;
            return 1'b1;
        endfunction

        function bit real_read(input logic [NOW_W-1:0] host, output logic [NOW_W-1:0] val);
            logic [NOW_W-1:0] m;
            longint           sum;
            longint           smax;
            longint           rs;
            longint           off;
            val = '0;
            smax = longint'({1'b0, VALUE_MAX});
            rs = longint'({1'b0, realtime_start});
            off = longint'({1'b0, rt_offset});
            if (!mono_read(host, m)) return 1'b0;
            sum = longint'({1'b0, m}) - longint'({1'b0, monotime_start});
            if (sum > smax - rs) return 1'b0;
            sum = sum + rs;
            if (sum > smax - off) return 1'b0;
            sum = sum + off;
            if (sum < 0) return 1'b0;
            val = sum[NOW_W-1:0];
            return 1'b1;
        endfunction

        function void note_request(logic op, logic [ID_W-1:0] id, logic [NOW_W-1:0] host,
                                   logic [SEC_W-1:0] sec, logic [NSEC_W-1:0] nsp);
            reading_t         e;
            logic [NOW_W-1:0] val;
            logic [NOW_W-1:0] cur;
            logic [63:0]      want;
            logic [63:0]      advance;
            e.status = STATUS_OK;
            e.seconds = '0;
            e.nanoseconds = '0;
            val = '0;
            requests++;
            if (op == OP_GET) begin
                if (id == CLK_MONOTONIC || id == CLK_MONOTONIC_COARSE || id == CLK_BOOTTIME) begin
                    if (!mono_read(host, val)) e.status = STATUS_OVERFLOW;
                end else if (id == CLK_REALTIME || id == CLK_REALTIME_COARSE) begin
                    if (!real_read(host, val)) e.status = STATUS_OVERFLOW;
                end else begin
                    e.status = STATUS_INVALID;
                end
                if (e.status == STATUS_OK) begin
                    e.seconds = SEC_W'({1'b0, val} / NS_PER_SEC);
                    e.nanoseconds = NSEC_W'({1'b0, val} % NS_PER_SEC);
                end
            end else if (id != CLK_REALTIME) begin
                e.status = STATUS_INVALID;
            end else begin
                want = 64'(sec) * NS_PER_SEC + 64'(nsp);
                if (!real_read(host, cur)) begin
                    e.status = STATUS_OVERFLOW;
                end else if (want > {1'b0, cur}) begin
                    advance = want - {1'b0, cur};
                    if (advance > {1'b0, VALUE_MAX - rt_offset}) begin
                        e.status = STATUS_INVALID;
                    end else begin
                        rt_offset = rt_offset + advance[NOW_W-1:0];
                    end
                end
            end
            by_status[e.status]++;
            expected_readings.push_back(e);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("tb: mismatch in %s on reading %0d: got %0d, expected %0d",
                     what, readings, got, want);
        endtask

        task check_reading(logic [1:0] st, logic [SEC_W-1:0] sec, logic [NSEC_W-1:0] ns);
            reading_t e;
            readings++;
            if (expected_readings.size() == 0) begin
                report_mismatch("reading with no request waiting", st, 0);
                return;
            end
            e = expected_readings.pop_front();
            if (st !== e.status) report_mismatch("status", st, e.status);
            if (sec !== e.seconds) report_mismatch("seconds", sec, e.seconds);
            if (ns !== e.nanoseconds) report_mismatch("nanoseconds", ns, e.nanoseconds);
        endtask
    endclass

endpackage

// ===== bench/tb.sv =====
// testbench top: drives requests and config writes, checks every reading against a predictor
`timescale 1ns / 1ps

module tb;

    import gmrc_pkg::*;
    import clock_check_pkg::*;

    localparam logic [ID_W-1:0]  CLK_ID_MAX  = {ID_W{1'b1}};
    localparam logic [NOW_W-1:0] EPOCH_NOW   = 63'd1_700_000_000_123_456_789;
    localparam logic [NOW_W-1:0] MONO_LAUNCH = 63'd5_000_000_000;
    localparam logic [NOW_W-1:0] MONO_HALF   = 63'h4000_0000_0000_0000;
    localparam logic [NOW_W-1:0] START_MIN   = 63'd1;
    localparam logic [SEC_W-1:0] BIG_SET_SEC = 34'd9_000_000_000;
    localparam int               HOLD_CYCLES = 300;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_operation;
    logic [ID_W-1:0]   s_clock_id;
    logic [NOW_W-1:0]  s_host_now;
    logic [SEC_W-1:0]  s_set_seconds;
    logic [NSEC_W-1:0] s_set_nanoseconds;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_status;
    logic [SEC_W-1:0]  m_seconds;
    logic [NSEC_W-1:0] m_nanoseconds;
    logic              cfg_write;
    logic              cfg_index;
    logic [NOW_W-1:0]  cfg_data;

    clock_checker      chk;
    bit                tx_steady;
    bit                rx_steady;
    bit                hold_req;
    logic [NOW_W-1:0]  host_base;

    guarded_monotonic_realtime_clock u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_clock_id        (s_clock_id),
        .s_host_now        (s_host_now),
        .s_set_seconds     (s_set_seconds),
        .s_set_nanoseconds (s_set_nanoseconds),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_seconds         (m_seconds),
        .m_nanoseconds     (m_nanoseconds),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && cfg_write === 1'b1) chk.write_register(cfg_index, cfg_data);
        if (aresetn === 1'b1 && s_valid === 1'b1 && s_ready === 1'b1)
            chk.note_request(s_operation, s_clock_id, s_host_now, s_set_seconds,
                             s_set_nanoseconds);
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            chk.check_reading(m_status, m_seconds, m_nanoseconds);
    end

    // result side: random stall per beat, plus one long hold on request
    initial begin
        int low;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            low = rx_steady ? 0 : $urandom_range(0, 6);
            if (hold_req) begin
                low = low + HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (low > 0) begin
                m_ready <= 1'b0;
                repeat (low) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    initial begin
        #10_000_000;
        $display("tb: timeout");
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_beat(input logic op, input logic [ID_W-1:0] id,
                             input logic [NOW_W-1:0] host, input logic [SEC_W-1:0] sec,
                             input logic [NSEC_W-1:0] nsp);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_clock_id <= id;
        s_host_now <= host;
        s_set_seconds <= sec;
        s_set_nanoseconds <= nsp;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chk.pending() != 0);
    endtask

    task automatic write_registers(input logic [NOW_W-1:0] rs, input logic [NOW_W-1:0] ms);
        cfg_write <= 1'b1;
        cfg_index <= CFG_REALTIME_START;
        cfg_data <= rs;
        @(posedge aclk);
        cfg_index <= CFG_MONOTIME_START;
        cfg_data <= ms;
        @(posedge aclk);
        cfg_write <= 1'b0;
    endtask

    // mostly advancing host samples, random if wide, and sets aimed near the current realtime
    task automatic send_random_requests(input int count, input bit wide);
        logic              op;
        logic [ID_W-1:0]   id;
        logic [NOW_W-1:0]  host;
        logic [SEC_W-1:0]  sec;
        logic [NSEC_W-1:0] nsp;
        logic [63:0]       want;
        int                pick;
        repeat (count) begin
            op = ($urandom_range(0, 99) < 70) ? OP_GET : OP_SET;
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                id = ID_W'($urandom_range(0, CLK_ID_MAX));
            end else if (op == OP_SET) begin
                id = CLK_REALTIME;
            end else begin
                case ($urandom_range(0, 4))
                    0: id = CLK_REALTIME;
                    1: id = CLK_MONOTONIC;
                    2: id = CLK_REALTIME_COARSE;
                    3: id = CLK_MONOTONIC_COARSE;
                    default: id = CLK_BOOTTIME;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (wide) begin
                host = NOW_W'({$urandom(), $urandom()});
            end else if (pick < 65) begin
                host_base = host_base + $urandom_range(1, 20000);
                host = host_base;
            end else if (pick < 85) begin
                host = host_base - $urandom_range(0, 3000);
            end else begin
                host = host_base + $urandom_range(0, 3);
            end
            pick = $urandom_range(0, 99);
            nsp = NSEC_W'($urandom());
            if (pick < 60) begin
                want = chk.realtime_guess(host) + $urandom_range(0, 2_000_000) - 64'd1_000_000;
                sec = SEC_W'(want / NS_PER_SEC);
                nsp = NSEC_W'(want % NS_PER_SEC);
            end else if (pick < 80) begin
                sec = SEC_W'(chk.realtime_guess(host) / NS_PER_SEC)
                    - SEC_W'($urandom_range(0, 100));
            end else if (pick < 90) begin
                sec = SEC_W'($urandom_range(0, 1000));
            end else begin
                sec = {2'b11, $urandom()};
            end
            send_beat(op, id, host, sec, nsp);
        end
    endtask

    initial begin
        chk = new();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        hold_req = 1'b0;
        host_base = '0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_operation <= OP_GET;
        s_clock_id <= CLK_REALTIME;
        s_host_now <= '0;
        s_set_seconds <= '0;
        s_set_nanoseconds <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_REALTIME_START;
        cfg_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values of both start registers
        send_beat(OP_GET, CLK_MONOTONIC, '0, '0, '0);
        send_beat(OP_GET, CLK_REALTIME, '0, '1, '1);
        for (int i = 0; i <= CLK_ID_MAX; i++) begin
            host_base = host_base + 1000;
            send_beat(OP_GET, ID_W'(i), host_base, '0, '0);
        end
        send_beat(OP_SET, CLK_MONOTONIC, host_base, SEC_W'(1), '0);
        send_beat(OP_SET, CLK_REALTIME, host_base, '0, '0);
        send_beat(OP_SET, CLK_REALTIME, host_base, SEC_W'(5), '0);
        // nanosecond part beyond one second
        send_beat(OP_SET, CLK_REALTIME, host_base, SEC_W'(5), '1);
        // offset would overflow
        send_beat(OP_SET, CLK_REALTIME, host_base, '1, '1);
        send_beat(OP_GET, CLK_REALTIME, host_base, '0, '0);
        send_beat(OP_GET, CLK_REALTIME_COARSE, host_base - 1, '0, '0);
        wait_drained();

        write_registers(EPOCH_NOW, MONO_LAUNCH);
        host_base = MONO_LAUNCH;
        send_random_requests(200, 1'b0);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_random_requests(120, 1'b0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        send_random_requests(180, 1'b0);
        wait_drained();

        // long result stall while requests keep coming
        hold_req = 1'b1;
        tx_steady = 1'b1;
        send_random_requests(40, 1'b0);
        tx_steady = 1'b0;
        wait_drained();

        write_registers(VALUE_MAX, VALUE_MAX);
        send_random_requests(40, 1'b0);
        wait_drained();

        // monotonic start above the kept value: realtime goes negative
        write_registers(START_MIN, MONO_HALF);
        send_random_requests(30, 1'b0);
        wait_drained();

        write_registers(EPOCH_NOW, START_MIN);
        send_random_requests(500, 1'b0);
        send_beat(OP_SET, CLK_REALTIME, host_base, BIG_SET_SEC, '0);
        send_random_requests(100, 1'b1);

        // monotonic saturation
        send_beat(OP_GET, CLK_MONOTONIC, VALUE_MAX, '0, '0);
        send_beat(OP_GET, CLK_MONOTONIC, '0, '0, '0);
        send_beat(OP_GET, CLK_REALTIME, '0, '0, '0);
        send_beat(OP_SET, CLK_REALTIME, '0, '1, '0);
        send_beat(OP_GET, CLK_ID_MAX, '0, '0, '0);
        wait_drained();
        repeat (60) @(posedge aclk);

        $display("tb: %0d requests, %0d readings (%0d ok, %0d invalid, %0d overflow), %0d errors",
                 chk.requests, chk.readings, chk.by_status[STATUS_OK],
                 chk.by_status[STATUS_INVALID], chk.by_status[STATUS_OVERFLOW], chk.errors);
        $display("tb: covered start registers at 1 and full scale, a %0d-cycle stall, saturation",
                 HOLD_CYCLES);
        if (chk.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gmrc_pkg.sv
rtl/gmrc_front.sv
rtl/gmrc_queue.sv
rtl/gmrc_back.sv
rtl/gmrc_div.sv
rtl/guarded_monotonic_realtime_clock.sv
bench/clock_check_pkg.sv
bench/tb.sv
